[hw/rtl/stx_etx_chunk_framer_with_ack_assert.svh]
// Assertion macros shared by the framer RTL files.
// Expects i_clk and i_rst_n in the scope of each use; empty when SYNTHESIS is set.
`ifndef STX_ETX_CHUNK_FRAMER_WITH_ACK_ASSERT_SVH
`define STX_ETX_CHUNK_FRAMER_WITH_ACK_ASSERT_SVH
`ifndef SYNTHESIS
`define SECF_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("secf: same-cycle check failed");
`define SECF_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("secf: next-cycle check failed");
`else
`define SECF_ASSERT_IMP(lbl, a, b)
`define SECF_ASSERT_NXT(lbl, a, b)
`endif
`endif

[hw/rtl/secf_pkg.sv]
// Shared types and constants of the chunk framer.
// No dependencies; imported by the fifo, front, back and top modules.
package secf_pkg;

    localparam int MAX_CHUNK_DEF = 28;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] FRAME_STOP  = 8'h03;

    localparam logic [4:0] LIMIT_RESET = 5'd28;
    localparam logic [7:0] ACK_RESET   = 8'h50;

    localparam logic CFG_LIMIT = 1'b0;
    localparam logic CFG_ACK   = 1'b1;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_ACK   = 2'd1,
        OP_FAIL  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] len;
        logic [7:0] sum;
    } t_cmd;

endpackage

[hw/rtl/secf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module secf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 28,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/secf_fifo.sv]
// Short command queue between the front and back parts of the framer.
// Depends on secf_pkg for the command type and depth.
`include "stx_etx_chunk_framer_with_ack_assert.svh"
module secf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  secf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output secf_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);
    import secf_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [QAW:0] DEPTH_V = (QAW + 1)'(QUEUE_DEPTH);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_count, n_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == DEPTH_V);

    `SECF_ASSERT_IMP(a_no_push_full, o_full, !i_push || i_pop)
    `SECF_ASSERT_NXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

[hw/rtl/secf_front.sv]
// Front part: accepts items, holds configuration, collects payload and
// issues frame and status commands. Depends on secf_pkg.
`include "stx_etx_chunk_framer_with_ack_assert.svh"
module secf_front #(
    parameter int MAX_CHUNK = secf_pkg::MAX_CHUNK_DEF,
    localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1,
    localparam int FW = $clog2(MAX_CHUNK + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_action,
    input  logic [7:0]     i_in_byte,
    input  logic           i_msg_end,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    input  logic           i_q_full,
    output logic           o_push,
    output secf_pkg::t_cmd o_cmd,
    input  logic           i_frame_done,
    output logic           o_ram_we,
    output logic [AW-1:0]  o_ram_waddr,
    output logic [7:0]     o_ram_wdata
);
    import secf_pkg::*;

    localparam logic [1:0] PH_COLLECT = 2'd0;
    localparam logic [1:0] PH_AWAIT   = 2'd1;
    localparam logic [1:0] PH_DISCARD = 2'd2;

    localparam logic [8:0] MAX_V = 9'(MAX_CHUNK);

    logic [4:0]    r_limit;
    logic [7:0]    r_ack;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_sum, n_sum;
    logic [1:0]    r_phase, n_phase;
    logic          r_final, n_final;
    logic          r_busy, n_busy;

    logic          acc;
    logic [FW-1:0] fill_new;
    logic [7:0]    sum_new;
    logic [8:0]    lim;
    t_cmd          cmd;
    logic          push;
    logic          we;

    // Stall on a full queue; hold next-chunk data while the payload is read out.
    assign o_stall = i_q_full || (r_busy && (r_phase == PH_COLLECT) && !i_action);
    assign acc     = i_valid && !o_stall;

    assign fill_new = r_fill + 1'b1;
    assign sum_new  = r_sum + i_in_byte;

    always_comb begin
        priority if (r_limit == 5'd0) begin
            lim = 9'd1;
        end else if (9'(r_limit) > MAX_V) begin
            lim = MAX_V;
        end else begin
            lim = 9'(r_limit);
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_sum   = r_sum;
        n_phase = r_phase;
        n_final = r_final;
        n_busy  = r_busy;
        push    = 1'b0;
        we      = 1'b0;
        cmd.op  = OP_FAIL;
        cmd.len = 8'd0;
        cmd.sum = 8'd0;
        if (i_frame_done) begin
            n_busy = 1'b0;
        end
        if (acc) begin
            if (i_action) begin
                if (r_phase == PH_AWAIT) begin
                    push = 1'b1;
                    if (i_in_byte == r_ack) begin
                        cmd.op  = OP_ACK;
                        n_phase = PH_COLLECT;
                    end else begin
                        cmd.op  = OP_FAIL;
                        n_phase = r_final ? PH_COLLECT : PH_DISCARD;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_AWAIT: begin
                        push = 1'b1;
                    end
                    PH_DISCARD: begin
                        if (i_msg_end) begin
                            n_phase = PH_COLLECT;
                        end
                    end
                    PH_COLLECT: begin
                        we     = 1'b1;
                        n_fill = fill_new;
                        n_sum  = sum_new;
                        if ((9'(fill_new) >= lim) || i_msg_end) begin
                            push    = 1'b1;
                            cmd.op  = OP_FRAME;
                            cmd.len = 8'(fill_new);
                            cmd.sum = sum_new;
                            n_fill  = '0;
                            n_sum   = 8'd0;
                            n_final = i_msg_end;
                            n_phase = PH_AWAIT;
                            n_busy  = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_COLLECT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_ack   <= ACK_RESET;
            r_fill  <= '0;
            r_sum   <= 8'd0;
            r_phase <= PH_COLLECT;
            r_final <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LIMIT: r_limit <= i_cfg_data[4:0];
                    CFG_ACK:   r_ack   <= i_cfg_data;
                    default:   r_ack   <= r_ack;
                endcase
            end
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_phase <= n_phase;
            r_final <= n_final;
            r_busy  <= n_busy;
        end
    end

    assign o_push      = push;
    assign o_cmd       = cmd;
    assign o_ram_we    = we;
    assign o_ram_waddr = r_fill[AW-1:0];
    assign o_ram_wdata = i_in_byte;

    `SECF_ASSERT_IMP(a_no_write_busy, we, !r_busy)
    `SECF_ASSERT_NXT(a_frame_awaits, push && (cmd.op == OP_FRAME), r_busy && (r_phase == PH_AWAIT))

endmodule

[hw/rtl/secf_back.sv]
// Back part: pops commands and sends frame bytes and status beats through
// an output register. Depends on secf_pkg; reads payload from secf_ram.
`include "stx_etx_chunk_framer_with_ack_assert.svh"
module secf_back #(
    parameter int MAX_CHUNK = secf_pkg::MAX_CHUNK_DEF,
    localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1,
    localparam int FW = $clog2(MAX_CHUNK + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  secf_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic [AW-1:0]  o_ram_raddr,
    input  logic [7:0]     i_ram_rdata,
    output logic           o_frame_done,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic [1:0]     o_out_kind,
    output logic           o_frame_last
);
    import secf_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_START = 3'd1;
    localparam logic [2:0] B_LEN   = 3'd2;
    localparam logic [2:0] B_PAY   = 3'd3;
    localparam logic [2:0] B_SUM   = 3'd4;
    localparam logic [2:0] B_STOP  = 3'd5;
    localparam logic [2:0] B_STAT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [FW-1:0] r_idx, n_idx;
    logic          r_rd_ok, n_rd_ok;
    t_op           r_op;
    logic [7:0]    r_len;
    logic [7:0]    r_sum;
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_obyte, n_obyte;
    logic [1:0]    r_okind, n_okind;
    logic          r_olast, n_olast;

    logic free;
    logic pop;
    logic load;
    logic done;

    assign free = !r_ovalid || !i_stall;
    assign pop  = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_rd_ok  = 1'b1;
        n_obyte  = r_obyte;
        n_okind  = r_okind;
        n_olast  = r_olast;
        load     = 1'b0;
        done     = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (pop) begin
                    n_idx   = '0;
                    n_rd_ok = 1'b0;
                    n_state = (i_head.op == OP_FRAME) ? B_START : B_STAT;
                end
            end
            B_START: begin
                if (free) begin
                    load    = 1'b1;
                    n_obyte = FRAME_START;
                    n_okind = KIND_BYTE;
                    n_olast = 1'b0;
                    n_state = B_LEN;
                end
            end
            B_LEN: begin
                if (free) begin
                    load    = 1'b1;
                    n_obyte = r_len;
                    n_okind = KIND_BYTE;
                    n_olast = 1'b0;
                    n_state = B_PAY;
                end
            end
            B_PAY: begin
                // After each address step, hold off until the registered read data is valid.
                if (free && r_rd_ok) begin
                    load    = 1'b1;
                    n_obyte = i_ram_rdata;
                    n_okind = KIND_BYTE;
                    n_olast = 1'b0;
                    n_idx   = r_idx + 1'b1;
                    n_rd_ok = 1'b0;
                    if ((8'(r_idx) + 8'd1) == r_len) begin
                        n_state = B_SUM;
                    end
                end
            end
            B_SUM: begin
                if (free) begin
                    load    = 1'b1;
                    n_obyte = r_sum;
                    n_okind = KIND_BYTE;
                    n_olast = 1'b0;
                    n_state = B_STOP;
                end
            end
            B_STOP: begin
                if (free) begin
                    load    = 1'b1;
                    done    = 1'b1;
                    n_obyte = FRAME_STOP;
                    n_okind = KIND_BYTE;
                    n_olast = 1'b1;
                    n_state = B_IDLE;
                end
            end
            B_STAT: begin
                if (free) begin
                    load    = 1'b1;
                    n_obyte = 8'd0;
                    n_okind = (r_op == OP_ACK) ? KIND_ACK : KIND_FAIL;
                    n_olast = 1'b1;
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        if (load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_idx    <= '0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_ok  <= n_rd_ok;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op  <= i_head.op;
            r_len <= i_head.len;
            r_sum <= i_head.sum;
        end
        r_obyte <= n_obyte;
        r_okind <= n_okind;
        r_olast <= n_olast;
    end

    assign o_pop        = pop;
    assign o_ram_raddr  = r_idx[AW-1:0];
    assign o_frame_done = done;
    assign o_valid      = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_out_kind   = r_okind;
    assign o_frame_last = r_olast;

    `SECF_ASSERT_NXT(a_done_idle, done, (r_state == B_IDLE) && r_ovalid && r_olast)

endmodule

[hw/rtl/stx_etx_chunk_framer_with_ack.sv]
// Chunk framer with acknowledge: message bytes in, STX/ETX frames and reply
// status beats out. An input beat is taken whenever the command queue has
// room; a data byte for the next chunk is held off until the current frame
// has been sent. The back part pops a command, then sends the start, length,
// payload, sum and stop bytes; the read of the first payload byte overlaps
// the start byte, and each later payload byte waits for the registered read
// of the payload RAM. A status command is popped and sent as one beat.
// Output stalls hold the output register and back-pressure through the queue.
// No clearing pass after reset.
`include "stx_etx_chunk_framer_with_ack_assert.svh"
module stx_etx_chunk_framer_with_ack #(
    parameter int MAX_CHUNK = secf_pkg::MAX_CHUNK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_in_byte,
    input  logic       i_msg_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_frame_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import secf_pkg::*;

    localparam int AW = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

    logic          push;
    t_cmd          cmd;
    logic          pop;
    t_cmd          head;
    logic          q_empty;
    logic          q_full;
    logic          frame_done;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    secf_front #(
        .MAX_CHUNK(MAX_CHUNK)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_in_byte    (i_in_byte),
        .i_msg_end    (i_msg_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (cmd),
        .i_frame_done (frame_done),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata)
    );

    secf_ram #(
        .WIDTH(8),
        .DEPTH(MAX_CHUNK)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    secf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    secf_back #(
        .MAX_CHUNK(MAX_CHUNK)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_frame_done (frame_done),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_out_kind   (o_out_kind),
        .o_frame_last (o_frame_last)
    );

    `SECF_ASSERT_IMP(a_pop_nonempty, pop, !q_empty)

endmodule
